/* sv/plc_pkg.sv */
// Package for the positional insert/delete list.
// Holds the command codes, cell operation codes and the cell control struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package plc_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int POS_W        = 5;
    localparam int DATA_W       = 32;
    localparam int CMD_W        = 2;
    localparam int CNT_OUT_W    = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_DUMP   = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        CO_HOLD = 2'd0,
        CO_INS  = 2'd1,
        CO_DEL  = 2'd2,
        CO_ROT  = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic [POS_W-1:0]   pos;
    } t_cell_ctl;

endpackage

`default_nettype wire

/* sv/plc_cell.sv */
// One storage cell of the list chain: holds one entry and takes its next value
// from itself, the incoming item value, a neighbour or the head entry. Depends on plc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module plc_cell
    import plc_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  wire logic                     i_clk,
    input  wire t_cell_ctl                i_ctl,
    input  wire logic [CNT_W-1:0]         i_count,
    input  wire logic signed [DATA_W-1:0] i_value,
    input  wire logic signed [DATA_W-1:0] i_left,
    input  wire logic signed [DATA_W-1:0] i_right,
    input  wire logic signed [DATA_W-1:0] i_first,
    output logic signed [DATA_W-1:0]      o_data
);

    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam logic [CMP_W-1:0] ME     = CMP_W'(IDX);
    localparam logic [CMP_W-1:0] ME_NXT = CMP_W'(IDX + 1);

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;
    logic [CMP_W-1:0]         w_pos;
    logic [CMP_W-1:0]         w_cnt;

    assign w_pos = CMP_W'(i_ctl.pos);
    assign w_cnt = CMP_W'(i_count);

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            CO_INS: begin
                if (ME > w_pos) begin
                    n_data = i_left;
                end else if (ME == w_pos) begin
                    n_data = i_value;
                end
            end
            CO_DEL: begin
                if (ME >= w_pos) begin
                    n_data = i_right;
                end
            end
            CO_ROT: begin
                // wrap head entry to the tail of the occupied part
                if (ME_NXT == w_cnt) begin
                    n_data = i_first;
                end else begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

/* sv/positional_insert_delete_list.sv */
// Positional insert/delete list: a chain of plc_cell stages with a small controller.
// Insert, delete, empty dump and unused codes: one result in the cycle after the item
// is taken; busy stays low, so a new item may follow every cycle.
// Dump of n entries: n results on consecutive cycles, registered from the dump state;
// busy is high in the dump state; the chain rotates the entries one place per cycle.
// Results cannot be stalled. Reset clears the count; entries are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module positional_insert_delete_list
    import plc_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [CMD_W-1:0]         i_command,
    input  wire logic [POS_W-1:0]         i_position,
    input  wire logic signed [DATA_W-1:0] i_value,
    output logic                          o_strobe,
    output logic                          o_success,
    output logic [CNT_OUT_W-1:0]          o_count,
    output logic                          o_empty_res,
    output logic signed [DATA_W-1:0]      o_element,
    output logic                          o_element_valid,
    output logic                          o_last
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_strobe, n_strobe;
    logic               r_success, n_success;
    logic               r_empty, n_empty;
    logic               r_valid, n_valid;
    logic               r_last, n_last;
    logic signed [DATA_W-1:0] r_element, n_element;
    logic [CNT_OUT_W-1:0]     r_cnt_out, n_cnt_out;

    logic               w_accept;
    logic               w_ins_ok;
    logic               w_del_ok;
    logic [CMP_W-1:0]   w_pos;
    logic [CMP_W-1:0]   w_cnt;
    logic [CNT_W+CNT_OUT_W-1:0] w_cnt_ext;
    logic [CNT_W-1:0]   w_idx_nxt;
    t_cell_ctl          w_ctl;
    t_cmd               w_cmd;
    logic signed [DATA_W-1:0] w_data [CAPACITY];

    assign busy     = r_state[1];
    assign w_accept = start && !busy;
    assign w_cmd    = t_cmd'(i_command);
    assign w_pos    = CMP_W'(i_position);
    assign w_cnt    = CMP_W'(r_count);
    assign w_ins_ok = (r_count < CAP_C) && (w_pos <= w_cnt);
    assign w_del_ok = (w_pos < w_cnt);
    assign w_idx_nxt = r_idx + 1'b1;

    always_comb begin
        w_ctl.op  = CO_HOLD;
        w_ctl.pos = i_position;
        if (r_state == S_DUMP) begin
            w_ctl.op = CO_ROT;
        end else if (w_accept) begin
            case (w_cmd)
                CMD_INSERT: begin
                    if (w_ins_ok) begin
                        w_ctl.op = CO_INS;
                    end
                end
                CMD_DELETE: begin
                    if (w_del_ok) begin
                        w_ctl.op = CO_DEL;
                    end
                end
                default: begin
                    w_ctl.op = CO_HOLD;
                end
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic signed [DATA_W-1:0] w_left;
            logic signed [DATA_W-1:0] w_right;
            if (g == 0) begin : g_head
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_data[g-1];
            end
            if (g == CAPACITY - 1) begin : g_tail
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_data[g+1];
            end
            plc_cell #(
                .IDX   (g),
                .CNT_W (CNT_W)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_count (r_count),
                .i_value (i_value),
                .i_left  (w_left),
                .i_right (w_right),
                .i_first (w_data[0]),
                .o_data  (w_data[g])
            );
        end
    endgenerate

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_strobe  = 1'b0;
        n_success = r_success;
        n_valid   = 1'b0;
        n_last    = r_last;
        n_element = r_element;
        if (r_state == S_DUMP) begin
            n_strobe  = 1'b1;
            n_success = 1'b1;
            n_valid   = 1'b1;
            n_element = w_data[0];
            n_last    = (w_idx_nxt == r_count);
            n_idx     = w_idx_nxt;
            if (w_idx_nxt == r_count) begin
                n_state = S_IDLE;
            end
        end else if (w_accept) begin
            n_strobe  = 1'b1;
            n_last    = 1'b1;
            n_element = '0;
            case (w_cmd)
                CMD_INSERT: begin
                    n_success = w_ins_ok;
                    if (w_ins_ok) begin
                        n_count = r_count + 1'b1;
                    end
                end
                CMD_DELETE: begin
                    n_success = w_del_ok;
                    if (w_del_ok) begin
                        n_count = r_count - 1'b1;
                    end
                end
                CMD_DUMP: begin
                    n_success = 1'b1;
                    if (r_count != '0) begin
                        n_strobe = 1'b0;
                        n_idx    = '0;
                        n_state  = S_DUMP;
                    end
                end
                default: begin
                    n_success = 1'b0;
                end
            endcase
        end
    end

    assign w_cnt_ext = (CNT_W + CNT_OUT_W)'(n_count);
    assign n_cnt_out = w_cnt_ext[CNT_OUT_W-1:0];
    assign n_empty   = (n_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_success <= n_success;
        r_valid   <= n_valid;
        r_last    <= n_last;
        r_element <= n_element;
        r_cnt_out <= n_cnt_out;
        r_empty   <= n_empty;
    end

    assign o_strobe        = r_strobe;
    assign o_success       = r_success;
    assign o_count         = r_cnt_out;
    assign o_empty_res     = r_empty;
    assign o_element       = r_element;
    assign o_element_valid = r_strobe && r_valid;
    assign o_last          = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("count above capacity");

    a_take_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !(w_cmd == CMD_DUMP && r_count != '0)) |=> o_strobe && o_last)
        else $error("item taken without a single result");

    a_dump_midway_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> busy)
        else $error("non-final dump result while idle");

    a_empty_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_empty_res == (r_count == '0)))
        else $error("empty flag disagrees with count");

    a_dump_stable_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && $past(busy)) |-> $stable(r_count))
        else $error("count moved during dump");

endmodule

`default_nettype wire

/* sim/positional_insert_delete_list_tb.sv */
// Testbench for positional_insert_delete_list: directed table then random commands,
// every result checked against the table's expected values or a shadow list kept in the bench.
// Depends on plc_pkg and positional_insert_delete_list.
`timescale 1ns / 1ps

module positional_insert_delete_list_tb;
    import plc_pkg::*;

    localparam int          CAPACITY     = CAPACITY_DEF;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          RANDOM_ITEMS = 50;
    localparam logic [1:0]  CMD_RESERVED = 2'd3;

    typedef struct packed {
        logic                     success;
        logic [CNT_OUT_W-1:0]     count;
        logic                     empty_res;
        logic signed [DATA_W-1:0] element;
        logic                     element_valid;
        logic                     last;
    } t_list_result;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;
        logic [4:0]        reps;
        logic              fixed;
        t_list_result      exp;
    } t_stim_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [CMD_W-1:0]         i_command = '0;
    logic [POS_W-1:0]         i_position = '0;
    logic signed [DATA_W-1:0] i_value = '0;
    logic                     o_strobe;
    logic                     o_success;
    logic [CNT_OUT_W-1:0]     o_count;
    logic                     o_empty_res;
    logic signed [DATA_W-1:0] o_element;
    logic                     o_element_valid;
    logic                     o_last;

    logic [DATA_W-1:0] shadow_entries [CAPACITY];
    int                shadow_count;
    t_list_result      cmd_results [$];
    t_list_result      awaited_results [$];
    t_stim_row         stim_table [$];
    int                mismatches = 0;
    int                cycles = 0;

    positional_insert_delete_list #(.CAPACITY(CAPACITY)) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_position      (i_position),
        .i_value         (i_value),
        .o_strobe        (o_strobe),
        .o_success       (o_success),
        .o_count         (o_count),
        .o_empty_res     (o_empty_res),
        .o_element       (o_element),
        .o_element_valid (o_element_valid),
        .o_last          (o_last)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_list_result list_result(logic ok, logic [DATA_W-1:0] elem,
                                                 logic ev, logic lst);
        t_list_result r;
        r.success       = ok;
        r.count         = shadow_count[CNT_OUT_W-1:0];
        r.empty_res     = (shadow_count == 0);
        r.element       = elem;
        r.element_valid = ev;
        r.last          = lst;
        return r;
    endfunction

    task automatic predict_list_command(input logic [CMD_W-1:0] cmd,
                                        input logic [POS_W-1:0] pos,
                                        input logic [DATA_W-1:0] val);
        int   j;
        logic ok;
        cmd_results.delete();
        ok = 1'b0;
        case (cmd)
            CMD_INSERT: begin
                if (shadow_count < CAPACITY && int'(pos) <= shadow_count) begin
                    for (j = shadow_count; j > int'(pos); j--)
                        shadow_entries[j] = shadow_entries[j-1];
                    shadow_entries[pos] = val;
                    shadow_count++;
                    ok = 1'b1;
                end
                cmd_results.push_back(list_result(ok, '0, 1'b0, 1'b1));
            end
            CMD_DELETE: begin
                if (int'(pos) < shadow_count) begin
                    for (j = int'(pos); j + 1 < shadow_count; j++)
                        shadow_entries[j] = shadow_entries[j+1];
                    shadow_count--;
                    ok = 1'b1;
                end
                cmd_results.push_back(list_result(ok, '0, 1'b0, 1'b1));
            end
            CMD_DUMP: begin
                if (shadow_count == 0) begin
                    cmd_results.push_back(list_result(1'b1, '0, 1'b0, 1'b1));
                end else begin
                    for (j = 0; j < shadow_count; j++)
                        cmd_results.push_back(list_result(1'b1, shadow_entries[j], 1'b1,
                                                          j + 1 == shadow_count));
                end
            end
            default: cmd_results.push_back(list_result(1'b0, '0, 1'b0, 1'b1));
        endcase
    endtask

    function automatic int idle_gap(int n);
        int r;
        if ((n / 10) % 4 == 3)
            return 0;
        r = $urandom_range(99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(3, 1);
        else if (r < 97)
            return $urandom_range(10, 4);
        return $urandom_range(40, 20);
    endfunction

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                             input logic [DATA_W-1:0] val, input logic fixed,
                             input t_list_result exp, input int gap);
        i_command  <= cmd;
        i_position <= pos;
        i_value    <= val;
        start      <= 1'b1;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        predict_list_command(cmd, pos, val);
        if (fixed)
            awaited_results.push_back(exp);
        else
            foreach (cmd_results[k])
                awaited_results.push_back(cmd_results[k]);
        if (gap > 0) begin
            start      <= 1'b0;
            i_command  <= $urandom;
            i_position <= $urandom;
            i_value    <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                           input logic [DATA_W-1:0] val, input int reps, input logic fixed,
                           input logic ok, input int cnt, input logic emp);
        t_stim_row row;
        row.cmd                 = cmd;
        row.pos                 = pos;
        row.val                 = val;
        row.reps                = reps[4:0];
        row.fixed               = fixed;
        row.exp.success         = ok;
        row.exp.count           = cnt[CNT_OUT_W-1:0];
        row.exp.empty_res       = emp;
        row.exp.element         = '0;
        row.exp.element_valid   = 1'b0;
        row.exp.last            = 1'b1;
        stim_table.push_back(row);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_list_result got;
        t_list_result exp;
        if (i_rst_n && o_strobe !== 1'b0) begin
            got = {o_success, o_count, o_empty_res, o_element, o_element_valid, o_last};
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: ok=%b cnt=%0d empty=%b elem=%h ev=%b last=%b",
                             got.success, got.count, got.empty_res, got.element,
                             got.element_valid, got.last);
            end else begin
                exp = awaited_results.pop_front();
                if (got !== exp) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp: ok=%b cnt=%0d empty=%b elem=%h ev=%b last=%b",
                                 exp.success, exp.count, exp.empty_res, exp.element,
                                 exp.element_valid, exp.last);
                        $display("         got: ok=%b cnt=%0d empty=%b elem=%h ev=%b last=%b",
                                 got.success, got.count, got.empty_res, got.element,
                                 got.element_valid, got.last);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int               n;
        int               r;
        int               k;
        logic             fill;
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] pos;
        t_list_result     none;

        none = '0;
        foreach (shadow_entries[j])
            shadow_entries[j] = '0;
        shadow_count = 0;

        // empty list, refusals, extremes, full list, drain
        add_row(CMD_DUMP,     0,  32'h0,         1,  1, 1'b1, 0,  1'b1);
        add_row(CMD_DELETE,   0,  32'h0,         1,  1, 1'b0, 0,  1'b1);
        add_row(CMD_INSERT,   1,  32'h0000_007B, 1,  1, 1'b0, 0,  1'b1);
        add_row(CMD_INSERT,   0,  32'h7FFF_FFFF, 1,  1, 1'b1, 1,  1'b0);
        add_row(CMD_INSERT,   0,  32'h8000_0000, 1,  1, 1'b1, 2,  1'b0);
        add_row(CMD_INSERT,   2,  32'hFFFF_FFFF, 1,  1, 1'b1, 3,  1'b0);
        add_row(CMD_DUMP,     31, 32'hFFFF_FFFF, 1,  0, 1'b0, 0,  1'b0);
        add_row(CMD_INSERT,   31, 32'h0000_0005, 1,  1, 1'b0, 3,  1'b0);
        add_row(CMD_DELETE,   3,  32'h0,         1,  1, 1'b0, 3,  1'b0);
        add_row(CMD_DELETE,   31, 32'h0,         1,  1, 1'b0, 3,  1'b0);
        add_row(CMD_RESERVED, 0,  32'h1234_5678, 1,  1, 1'b0, 3,  1'b0);
        add_row(CMD_DELETE,   1,  32'h0,         1,  1, 1'b1, 2,  1'b0);
        add_row(CMD_INSERT,   1,  32'h5A5A_5A5A, 1,  1, 1'b1, 3,  1'b0);
        add_row(CMD_DUMP,     0,  32'h0,         1,  0, 1'b0, 0,  1'b0);
        add_row(CMD_INSERT,   0,  32'h0000_0100, 13, 0, 1'b0, 0,  1'b0);
        add_row(CMD_INSERT,   0,  32'h0000_0001, 1,  1, 1'b0, 16, 1'b0);
        add_row(CMD_INSERT,   16, 32'h0000_0002, 1,  1, 1'b0, 16, 1'b0);
        add_row(CMD_DUMP,     0,  32'h0,         1,  0, 1'b0, 0,  1'b0);
        add_row(CMD_DELETE,   15, 32'h0,         1,  1, 1'b1, 15, 1'b0);
        add_row(CMD_INSERT,   15, 32'hFFFF_0000, 1,  1, 1'b1, 16, 1'b0);
        add_row(CMD_DUMP,     0,  32'h0,         1,  0, 1'b0, 0,  1'b0);
        add_row(CMD_DELETE,   0,  32'h0,         16, 0, 1'b0, 0,  1'b0);
        add_row(CMD_DUMP,     0,  32'h0,         1,  1, 1'b1, 0,  1'b1);
        add_row(CMD_RESERVED, 31, 32'hFFFF_FFFF, 1,  1, 1'b0, 0,  1'b1);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        n = 0;
        foreach (stim_table[i]) begin
            for (k = 0; k < int'(stim_table[i].reps); k++) begin
                send_item(stim_table[i].cmd, stim_table[i].pos, stim_table[i].val + k,
                          stim_table[i].fixed, stim_table[i].exp, idle_gap(n));
                n++;
            end
        end

        // alternate fill-heavy and drain-heavy stretches
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            fill = ((n / 25) % 2 == 0);
            r = $urandom_range(99);
            if (r < 5)
                cmd = CMD_RESERVED;
            else if (r < 20)
                cmd = CMD_DUMP;
            else if (r < (fill ? 80 : 40))
                cmd = CMD_INSERT;
            else
                cmd = CMD_DELETE;
            if ($urandom_range(9) < 8) begin
                if (cmd == CMD_DELETE)
                    pos = (shadow_count > 0) ? $urandom_range(shadow_count - 1) : '0;
                else
                    pos = $urandom_range(shadow_count);
            end else begin
                pos = $urandom_range(31);
            end
            send_item(cmd, pos, $urandom, 1'b0, none, idle_gap(n));
        end
        start <= 1'b0;

        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* filelist.f */
sv/plc_pkg.sv
sv/plc_cell.sv
sv/positional_insert_delete_list.sv
sim/positional_insert_delete_list_tb.sv
